// ===== rtl/core/trt_pkg.sv =====
// Shared types and constants of the timed release table.
// Used by trt_ctrl, trt_dpath and timed_release_table; depends on nothing.
package trt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// result field widths
	localparam int COUNT_FIELD_W = 5;
	localparam int SLOT_FIELD_W = 4;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_POLL = 1'b1;

	typedef enum logic [1:0] {
		ST_ADDED = 2'd0,
		ST_FULL = 2'd1,
		ST_RELEASED = 2'd2,
		ST_NONE = 2'd3
	} trt_status_t;

	typedef struct packed {
		logic mode;
		logic [31:0] release_time;
		logic [31:0] poll_time;
		logic [15:0] payload_tag;
		logic [63:0] fee_limit;
		logic [1:0] send_method;
	} trt_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] released_tag;
		logic [31:0] released_target;
		logic [63:0] released_fee;
		logic [1:0] released_method;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic has_earliest;
		logic [31:0] earliest_time;
		logic [SLOT_FIELD_W-1:0] earliest_slot;
	} trt_out_t;

	typedef struct packed {
		logic [31:0] target;
		logic [15:0] tag;
		logic [63:0] fee;
		logic [1:0] method;
	} trt_entry_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic wr_en;
		logic wr_from_rd;
		logic [ADDR_W-1:0] wr_addr;
		logic inc_count;
		logic dec_count;
		logic set_status;
		trt_status_t status;
		logic take_release;
		logic min_en;
		logic emit;
	} trt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic due;
		logic full;
	} trt_sts_t;

endpackage

// ===== rtl/core/trt_ctrl.sv =====
// Sequencer of the timed release table: add, find, compact and minimum scan.
// Depends on trt_pkg; drives trt_dpath through trt_cmd_t.
module trt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic start_mode,
	input trt_pkg::trt_sts_t sts,
	output trt_pkg::trt_cmd_t cmd,
	output logic busy
);
	import trt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_FIND,
		S_CMP,
		S_MIN
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [ADDR_W-1:0] wp_q, wp_d;
	logic rvld_q, rvld_d;
	logic busy_q, busy_d;

	assign busy = busy_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		idx_d = idx_q;
		wp_d = wp_q;
		rvld_d = 1'b0;
		busy_d = busy_q;
		cmd.rd_addr = idx_q[ADDR_W-1:0];
		cmd.wr_addr = wp_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					busy_d = 1'b1;
					idx_d = '0;
					state_d = (start_mode == MODE_ADD) ? S_ADD : S_FIND;
				end
			end
			S_ADD: begin
				cmd.set_status = 1'b1;
				idx_d = '0;
				state_d = S_MIN;
				if (sts.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.status = ST_ADDED;
					cmd.wr_en = 1'b1;
					cmd.wr_addr = sts.count[ADDR_W-1:0];
					cmd.inc_count = 1'b1;
				end
			end
			S_FIND: begin
				// reads issue one per cycle; the compare acts on the registered read data
				if (rvld_q && sts.due) begin
					cmd.take_release = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status = ST_RELEASED;
					wp_d = ADDR_W'(idx_q - 1'b1);
					state_d = S_CMP;
				end else if (idx_q < sts.count) begin
					cmd.rd_en = 1'b1;
					idx_d = idx_q + 1'b1;
					rvld_d = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status = ST_NONE;
					idx_d = '0;
					state_d = S_MIN;
				end
			end
			S_CMP: begin
				// read slot k+1, write it to slot k on the next beat
				if (rvld_q) begin
					cmd.wr_en = 1'b1;
					cmd.wr_from_rd = 1'b1;
					wp_d = wp_q + 1'b1;
				end
				if (idx_q < sts.count) begin
					cmd.rd_en = 1'b1;
					idx_d = idx_q + 1'b1;
					rvld_d = 1'b1;
				end else if (!rvld_q) begin
					cmd.dec_count = 1'b1;
					idx_d = '0;
					state_d = S_MIN;
				end
			end
			S_MIN: begin
				if (rvld_q) begin
					cmd.min_en = 1'b1;
				end
				if (idx_q < sts.count) begin
					cmd.rd_en = 1'b1;
					idx_d = idx_q + 1'b1;
					rvld_d = 1'b1;
				end else if (!rvld_q) begin
					cmd.emit = 1'b1;
					busy_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				busy_d = 1'b0;
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			wp_q <= '0;
			rvld_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			wp_q <= wp_d;
			rvld_q <= rvld_d;
			busy_q <= busy_d;
		end
	end

`ifndef SYNTH
	// reads never reach past the held entries
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (idx_q < sts.count))
		else $error("trt_ctrl: read beyond held entries");

	// compaction write trails its read
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en && cmd.wr_en) |-> (cmd.wr_addr != cmd.rd_addr))
		else $error("trt_ctrl: read and write collide");

	// idle means ready for a new beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !busy_q)
		else $error("trt_ctrl: busy while idle");
`endif

endmodule

// ===== rtl/core/trt_dpath.sv =====
// Datapath of the timed release table: entry memory, count, release and minimum registers.
// Depends on trt_pkg; controlled by trt_ctrl through trt_cmd_t.
module trt_dpath (
	input logic clk,
	input logic arst_n,
	input trt_pkg::trt_in_t item,
	input trt_pkg::trt_cmd_t cmd,
	output trt_pkg::trt_sts_t sts,
	output logic done,
	output trt_pkg::trt_out_t result
);
	import trt_pkg::*;

	trt_entry_t mem [TABLE_DEPTH];
	trt_entry_t rdata_s1;
	logic [ADDR_W-1:0] raddr_s1;
	trt_entry_t entry_q;
	trt_entry_t wdata;
	logic [31:0] now_q;
	logic [CNT_W-1:0] count_q;
	trt_status_t status_q;
	trt_entry_t rel_q;
	logic [31:0] best_q;
	logic [ADDR_W-1:0] best_slot_q;
	logic done_q;
	trt_out_t result_q;
	trt_out_t result_d;
	logic has;

	assign wdata = cmd.wr_from_rd ? rdata_s1 : entry_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[cmd.rd_addr];
			raddr_s1 <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			entry_q.target <= item.release_time;
			entry_q.tag <= item.payload_tag;
			entry_q.fee <= item.fee_limit;
			entry_q.method <= item.send_method;
			now_q <= item.poll_time;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.load_item) begin
			rel_q <= '0;
		end else if (cmd.take_release) begin
			rel_q <= rdata_s1;
		end
		// slot 0 seeds the minimum; ties keep the lower slot
		if (cmd.min_en && (raddr_s1 == '0 || rdata_s1.target < best_q)) begin
			best_q <= rdata_s1.target;
			best_slot_q <= raddr_s1;
		end
		if (cmd.emit) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.inc_count) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.dec_count) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign has = (count_q != '0);

	always_comb begin
		result_d.status = status_q;
		result_d.released_tag = rel_q.tag;
		result_d.released_target = rel_q.target;
		result_d.released_fee = rel_q.fee;
		result_d.released_method = rel_q.method;
		result_d.entry_count = COUNT_FIELD_W'(count_q);
		result_d.has_earliest = has;
		result_d.earliest_time = has ? best_q : '0;
		result_d.earliest_slot = has ? SLOT_FIELD_W'(best_slot_q) : '0;
	end

	assign sts.count = count_q;
	assign sts.due = (rdata_s1.target <= now_q);
	assign sts.full = (count_q == CNT_W'(TABLE_DEPTH));
	assign done = done_q;
	assign result = result_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("trt_dpath: count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc_count |-> !sts.full)
		else $error("trt_dpath: add into full table");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_count |-> (count_q != '0))
		else $error("trt_dpath: removal from empty table");
`endif

endmodule

// ===== rtl/core/timed_release_table.sv =====
// Timed release table: ordered table of scheduled entries released by time.
// Usage:
//   Drive item and raise start while busy is low; the beat is taken on that edge.
//   item.mode = add appends an entry (or reports full); mode = poll releases the
//   first entry in table order whose target time is at or before poll_time,
//   then closes the gap. Each beat yields exactly one result: done is high for a
//   single cycle with result valid, and it cannot be held off.
// Sequence of an operation:
//   add: one write of the entry, then one minimum-scan read per held slot.
//   poll: one find read per slot up to the first due entry, one compaction
//   read and write per later slot, then one minimum-scan read per held slot,
//   limited by the single read and single write port of the entry memory.
//   busy drops on the edge that loads the result; the next start can be taken
//   on the edge that ends the done cycle.
// Reset (arst_n low) empties the table and clears busy and done; entry storage
// is not cleared since slots at or above the count are never read.
// Depends on trt_pkg, trt_ctrl and trt_dpath.
module timed_release_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	input trt_pkg::trt_in_t item,
	output logic busy,
	output logic done,
	output trt_pkg::trt_out_t result
);
	import trt_pkg::*;

	trt_cmd_t cmd;
	trt_sts_t sts;

	trt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.start_mode(item.mode),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	trt_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.done(done),
		.result(result)
	);

endmodule
